[src/tcw_pkg.sv]
// Package for the text console writer: sequencer state type, character codes
// and cell constants shared by the console logic.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   // Field widths of the request and response channels.
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 12;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = 12;

   // Line geometry: 128 cells per line, column held in the low bits.
   localparam int LINE_CELLS = 128;

   // Cell contents: attribute nibble over the character byte.
   localparam logic [CELL_W-1:0] BLANK_CELL = 12'hF20;
   localparam logic [3:0]        ATTR_NIB   = 4'hF;

   // Control characters.
   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_DEL = 8'd127;

   // Request function codes.
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINE_FILL,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK,
      ST_FINISH
   } state_type;

endpackage

[src/text_console_writer.sv]
// Text console writer: teletype-style cursor control over a character buffer
// with line feed, backspace and scrolling. Depends on tcw_pkg.
`timescale 1ns / 1ps

// Usage
// A request carries func, ch and read_addr. func = put writes the byte ch at
// the cursor (backspace, delete, carriage return and line feed are handled as
// controls); func = read returns the cell at read_addr, or 0 beyond the buffer.
// Every request gives exactly one response with the cursor column and row after
// the request, and the cell data for a read (0 for a put).
// Reads, carriage return, backspace and printable bytes that need no scroll go
// from request acceptance through the finish state to the response register.
// A line feed first blanks each cell up to the line end. A scroll, when the
// cursor runs past the last cell, uses one buffer memory port pair to copy
// each cell up one line, then blanks the last line. One request is in work at
// a time: req_stall stays high until the response has been loaded into the
// output register.
// After reset the buffer is swept to blank, one cell a cycle, from cell 0 to the
// last cell; requests are stalled meanwhile and the cursor sits at 0.
// When rsp_stall is high while a response is valid, the response register holds
// its contents and the sequencer waits in its final state before taking the next request.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int CELLS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [CHAR_W-1:0] req_ch,
   input  logic [ADDR_W-1:0] req_read_addr,
   // Response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [CELL_W-1:0] rsp_cell_data
);

   // Memory index width, cursor width (room to pass the end by up to a line),
   // and widths for range checks.
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = $clog2(CELLS + LINE_CELLS);
   localparam int XW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
   localparam int EXT_W = PW + 5;
   localparam int KEEP  = CELLS - LINE_CELLS;

   // Character buffer.
   logic [CELL_W-1:0] text_buf_ff [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   // Control and payload registers.
   state_type         state_ff, state_in;
   logic [PW-1:0]     cursor_ff, cursor_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [AW-1:0]     copy_dst_ff, copy_dst_in;
   logic              is_read_ff, is_read_in;
   logic              read_oor_ff, read_oor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory port controls.
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   // Decoded conditions.
   logic [PW-1:0]     cursor_inc;
   logic [PW-1:0]     cursor_dec;
   logic              cur_in_range;
   logic              inc_full;
   logic              line_last;
   logic              cnt_last;
   logic              rsp_free;
   logic              is_bs;
   logic              is_lf;
   logic              is_cr;
   logic [XW-1:0]     raddr_ext;
   logic              raddr_in_range;
   logic [EXT_W-1:0]  cursor_ext;

   // Cursor arithmetic and request decode.
   always_comb begin
      cursor_inc     = cursor_ff + 1'b1;
      cursor_dec     = cursor_ff - 1'b1;
      cur_in_range   = cursor_ff < PW'(CELLS);
      inc_full       = cursor_inc >= PW'(CELLS);
      line_last      = cursor_ff[COL_W-1:0] == COL_W'(LINE_CELLS - 1);
      cnt_last       = cnt_ff == AW'(CELLS - 1);
      rsp_free       = !rsp_valid_ff || !rsp_stall;
      is_bs          = (req_ch == CH_BS) || (req_ch == CH_DEL);
      is_lf          = req_ch == CH_LF;
      is_cr          = req_ch == CH_CR;
      raddr_ext      = XW'(req_read_addr);
      raddr_in_range = raddr_ext < XW'(CELLS);
      cursor_ext     = EXT_W'(cursor_ff);
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_READ) begin
                  state_in = ST_FINISH;
               end else if (is_lf) begin
                  state_in = ST_LINE_FILL;
               end else if (!is_bs && !is_cr && inc_full) begin
                  state_in = ST_SCROLL_COPY;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LINE_FILL: begin
            if (line_last) begin
               state_in = inc_full ? ST_SCROLL_COPY : ST_FINISH;
            end
         end
         ST_SCROLL_COPY: begin
            if (cnt_last) begin
               state_in = ST_SCROLL_BLANK;
            end
         end
         ST_SCROLL_BLANK: begin
            if (!copy_pend_ff && cnt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs: memory port controls and register updates.
   always_comb begin
      cursor_in    = cursor_ff;
      cnt_in       = cnt_ff;
      copy_pend_in = 1'b0;
      copy_dst_in  = copy_dst_ff;
      is_read_in   = is_read_ff;
      read_oor_in  = read_oor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = BLANK_CELL;
      mem_re       = 1'b0;
      mem_raddr    = cnt_ff;

      unique case (state_ff)
         // Sweep the buffer to blank after reset.
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
         end
         // Take a request and do the single-cycle part of it.
         ST_IDLE: begin
            cnt_in = AW'(LINE_CELLS);
            if (req_valid) begin
               is_read_in  = req_func == FUNC_READ;
               read_oor_in = !raddr_in_range;
               if (req_func == FUNC_READ) begin
                  mem_re    = 1'b1;
                  mem_raddr = raddr_ext[AW-1:0];
               end else if (is_bs) begin
                  if (cursor_ff[COL_W-1:0] != '0) begin
                     cursor_in = cursor_dec;
                     mem_we    = 1'b1;
                     mem_waddr = cursor_dec[AW-1:0];
                  end
               end else if (is_cr) begin
                  cursor_in = {cursor_ff[PW-1:COL_W], COL_W'(0)};
               end else if (!is_lf) begin
                  mem_we    = 1'b1;
                  mem_waddr = cursor_ff[AW-1:0];
                  mem_wdata = {ATTR_NIB, req_ch};
                  cursor_in = cursor_inc;
               end
            end
         end
         // Line feed: blank one cell a cycle up to the line end.
         ST_LINE_FILL: begin
            cnt_in = AW'(LINE_CELLS);
            if (cur_in_range) begin
               mem_we    = 1'b1;
               mem_waddr = cursor_ff[AW-1:0];
            end
            cursor_in = cursor_inc;
         end
         // Scroll: read each cell one line down, write it one line up in the next cycle.
         ST_SCROLL_COPY: begin
            mem_re       = 1'b1;
            mem_raddr    = cnt_ff;
            copy_pend_in = 1'b1;
            copy_dst_in  = cnt_ff - AW'(LINE_CELLS);
            if (copy_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = copy_dst_ff;
               mem_wdata = rd_data_ff;
            end
            cnt_in = cnt_last ? AW'(KEEP) : cnt_ff + 1'b1;
         end
         // Finish the last copy, then blank the last line.
         ST_SCROLL_BLANK: begin
            mem_we = 1'b1;
            if (copy_pend_ff) begin
               mem_waddr = copy_dst_ff;
               mem_wdata = rd_data_ff;
            end else begin
               mem_waddr = cnt_ff;
               cnt_in    = cnt_ff + 1'b1;
               if (cnt_last) begin
                  cursor_in = PW'(KEEP);
               end
            end
         end
         // Load the response register once it is free.
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = cursor_ff[COL_W-1:0];
               rsp_row_in   = cursor_ext[COL_W+ROW_W-1:COL_W];
               rsp_data_in  = (is_read_ff && !read_oor_ff) ? rd_data_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Buffer memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_buf_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= text_buf_ff[mem_raddr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cursor_ff    <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      copy_dst_ff <= copy_dst_in;
      is_read_ff  <= is_read_in;
      read_oor_ff <= read_oor_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Port drive.
   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_data  = rsp_data_ff;

   // The cursor is always inside the buffer while waiting for a request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cursor_ff < PW'(CELLS)))
      else $error("cursor outside buffer while idle");

   // A new response only appears after the final sequencer state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish state");

   // An accepted request always takes the sequencer out of idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

   // A pending copy write exists only during a scroll.
   assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> (state_ff == ST_SCROLL_COPY || state_ff == ST_SCROLL_BLANK))
      else $error("copy write pending outside scroll");

   // A scroll always leaves the cursor at the start of the last line.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL_BLANK && state_in == ST_FINISH) |=>
         (cursor_ff == PW'(KEEP)))
      else $error("cursor not on last line after scroll");

endmodule

[sim/text_console_writer_tb.sv]
// Testbench for text_console_writer: a table of directed requests followed by
// random console traffic, each response checked against the table's expected
// value or a console model in the bench. Depends on tcw_pkg and the DUT RTL.
`timescale 1ns / 1ps

module text_console_writer_tb
   import tcw_pkg::*;
();

   localparam int CELLS          = 4096;
   localparam int RANDOM_ITEMS   = 1950;
   localparam int HOLDOFF_CYCLES = 500;
   localparam int DRAIN_CYCLES   = 300;

   // One response as seen on the result channel.
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] data;
   } console_status_type;

   // One row of the directed table. Rows with typed set carry their expected
   // response; the others are checked against the console model.
   typedef struct packed {
      logic              func;
      logic [CHAR_W-1:0] ch;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        reps;
      logic              typed;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] data;
   } dir_row_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_func      = FUNC_PUT;
   logic [CHAR_W-1:0] req_ch        = '0;
   logic [ADDR_W-1:0] req_read_addr = '0;
   logic              rsp_stall     = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [COL_W-1:0]  rsp_cursor_col;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [CELL_W-1:0] rsp_cell_data;

   // Console model state and the responses still owed by the block.
   logic [CELL_W-1:0]  screen_model [CELLS];
   int unsigned        cursor_model;
   console_status_type awaited_status [$];

   int mismatch_count = 0;
   int put_count      = 0;
   int read_count     = 0;
   int lf_count       = 0;
   int scroll_count   = 0;
   int random_items   = 0;
   int sender_quiet   = 0;
   int holdoff_asked  = 0;
   int holdoff_taken  = 0;
   int holdoff_left   = 0;
   int stall_left     = 0;
   int stall_quiet    = 0;

   // Directed requests: reset contents, both ends of the buffer, backspace and
   // delete at column 0, character extremes, carriage return, line feed, and a
   // line feed on the last line that scrolls the buffer.
   dir_row_type directed_rows [24] = '{
      '{FUNC_READ, 8'h00,  12'd0,    8'd1,  1'b1, 7'd0, 5'd0,  BLANK_CELL},
      '{FUNC_READ, 8'h00,  12'd4095, 8'd1,  1'b1, 7'd0, 5'd0,  BLANK_CELL},
      '{FUNC_PUT,  CH_BS,  12'd0,    8'd1,  1'b1, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  CH_DEL, 12'd0,    8'd1,  1'b1, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  8'h41,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  8'h00,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  8'hFF,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_READ, 8'h00,  12'd0,    8'd1,  1'b1, 7'd3, 5'd0,  12'hF41},
      '{FUNC_READ, 8'h00,  12'd1,    8'd1,  1'b1, 7'd3, 5'd0,  12'hF00},
      '{FUNC_READ, 8'h00,  12'd2,    8'd1,  1'b1, 7'd3, 5'd0,  12'hFFF},
      '{FUNC_PUT,  CH_BS,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_READ, 8'h00,  12'd2,    8'd1,  1'b1, 7'd2, 5'd0,  BLANK_CELL},
      '{FUNC_PUT,  CH_DEL, 12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  CH_CR,  12'd0,    8'd1,  1'b1, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  8'h7E,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  CH_LF,  12'd0,    8'd1,  1'b1, 7'd0, 5'd1,  12'h000},
      '{FUNC_READ, 8'h00,  12'd0,    8'd1,  1'b1, 7'd0, 5'd1,  12'hF7E},
      '{FUNC_PUT,  8'h80,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  CH_LF,  12'd0,    8'd30, 1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  8'h5A,  12'd0,    8'd1,  1'b0, 7'd0, 5'd0,  12'h000},
      '{FUNC_PUT,  CH_LF,  12'd0,    8'd1,  1'b1, 7'd0, 5'd31, 12'h000},
      '{FUNC_READ, 8'h00,  12'd3840, 8'd1,  1'b1, 7'd0, 5'd31, 12'hF5A},
      '{FUNC_READ, 8'h00,  12'd3968, 8'd1,  1'b1, 7'd0, 5'd31, BLANK_CELL},
      '{FUNC_READ, 8'h00,  12'd0,    8'd1,  1'b1, 7'd0, 5'd31, 12'hF80}
   };

   text_console_writer #(
      .CELLS(CELLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_ch(req_ch),
      .req_read_addr(req_read_addr),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_data(rsp_cell_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one request to the console model and return the response it owes.
   function automatic console_status_type predict_console(logic func,
                                                          logic [CHAR_W-1:0] c,
                                                          logic [ADDR_W-1:0] addr);
      console_status_type st;
      int unsigned        line_end;
      int                 i;
      st.data = '0;
      if (func == FUNC_PUT) begin
         if (c == CH_BS || c == CH_DEL) begin
            // Step back and blank, except at the start of a line.
            if (cursor_model % LINE_CELLS != 0) begin
               cursor_model--;
               screen_model[cursor_model] = BLANK_CELL;
            end
         end else if (c == CH_CR) begin
            cursor_model -= cursor_model % LINE_CELLS;
         end else if (c == CH_LF) begin
            // Blank to the end of the line and land on the next line start.
            line_end = (cursor_model | (LINE_CELLS - 1)) + 1;
            while (cursor_model < line_end) begin
               if (cursor_model < CELLS) screen_model[cursor_model] = BLANK_CELL;
               cursor_model++;
            end
         end else begin
            if (cursor_model < CELLS) screen_model[cursor_model] = {ATTR_NIB, c};
            cursor_model++;
         end
         // Past the last cell: move every line up and blank the last one.
         if (cursor_model >= CELLS) begin
            for (i = 0; i < CELLS - LINE_CELLS; i++) screen_model[i] = screen_model[i + LINE_CELLS];
            for (i = CELLS - LINE_CELLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
            cursor_model = CELLS - LINE_CELLS;
            scroll_count++;
         end
      end else if (addr < CELLS) begin
         st.data = screen_model[addr];
      end
      st.col = cursor_model[6:0];
      st.row = cursor_model[11:7];
      return st;
   endfunction

   // Mostly printable ASCII, sometimes any byte but backspace, line feed, carriage return and delete.
   function automatic logic [CHAR_W-1:0] text_byte();
      logic [CHAR_W-1:0] b;
      if ($urandom_range(0, 9) < 8) return CHAR_W'($urandom_range(8'h20, 8'h7E));
      do b = CHAR_W'($urandom_range(0, 255));
      while (b == CH_BS || b == CH_LF || b == CH_CR || b == CH_DEL);
      return b;
   endfunction

   // Idle cycles before the next request: mostly none or short, a few long,
   // and now and then a run of back-to-back requests.
   function automatic int sender_gap();
      int r;
      if (sender_quiet > 0) begin
         sender_quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 82) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(5, 30);
      if (r < 96) return $urandom_range(60, 150);
      sender_quiet = $urandom_range(20, 80);
      return 0;
   endfunction

   // Offer one request, wait for it to be taken, and record the response owed.
   task automatic send_request(logic func, logic [CHAR_W-1:0] c, logic [ADDR_W-1:0] addr,
                               logic typed, console_status_type typed_status);
      int                 gap;
      console_status_type st;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_ch        <= c;
      req_read_addr <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      st = predict_console(func, c, addr);
      awaited_status.push_back(typed ? typed_status : st);
      if (func == FUNC_READ) read_count++;
      else put_count++;
      if (func == FUNC_PUT && c == CH_LF) lf_count++;
   endtask

   // Response side: check each accepted response, then choose the next stall.
   always @(posedge clock) begin : response_side
      console_status_type want;
      int                 r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_status.size() == 0) begin
            $display("%0t: response with no request waiting: col %0d row %0d data %h",
                     $time, rsp_cursor_col, rsp_cursor_row, rsp_cell_data);
            mismatch_count++;
         end else begin
            want = awaited_status.pop_front();
            if (rsp_cursor_col !== want.col) begin
               $display("%0t: cursor_col expected %0d, got %0d", $time, want.col,
                        rsp_cursor_col);
               mismatch_count++;
            end
            if (rsp_cursor_row !== want.row) begin
               $display("%0t: cursor_row expected %0d, got %0d", $time, want.row,
                        rsp_cursor_row);
               mismatch_count++;
            end
            if (rsp_cell_data !== want.data) begin
               $display("%0t: cell_data expected %h, got %h", $time, want.data,
                        rsp_cell_data);
               mismatch_count++;
            end
         end
      end
      // A long hold-off on request, otherwise random stalls with quiet stretches.
      if (holdoff_asked != holdoff_taken) begin
         holdoff_taken++;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_quiet > 0) begin
         stall_quiet--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_stall <= 1'b0;
         end else if (r < 85) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else if (r < 93) begin
            stall_left = $urandom_range(10, 60);
            rsp_stall <= 1'b1;
         end else begin
            stall_quiet = $urandom_range(100, 300);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Request side: reset, the directed table, then random console traffic.
   initial begin : request_side
      int          n;
      int          k;
      int          r;
      int          next_holdoff_at;
      logic [11:0] row_base;
      for (n = 0; n < CELLS; n++) screen_model[n] = BLANK_CELL;
      cursor_model = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         for (k = 0; k < directed_rows[n].reps; k++) begin
            send_request(directed_rows[n].func, directed_rows[n].ch, directed_rows[n].addr,
                         directed_rows[n].typed,
                         '{directed_rows[n].col, directed_rows[n].row, directed_rows[n].data});
         end
      end

      // Random traffic in bursts: text lines, reads, backspaces, blank lines
      // and noise. Two long response hold-offs fall inside this part.
      next_holdoff_at = 400;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= next_holdoff_at) begin
            holdoff_asked <= holdoff_asked + 1;
            next_holdoff_at += 900;
         end
         r = $urandom_range(0, 99);
         if (r < 45) begin
            // A line of text, sometimes long enough to wrap, then its ending.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 60);
            repeat (n) send_request(FUNC_PUT, text_byte(), ADDR_W'($urandom_range(0, 4095)),
                                    1'b0, '0);
            k = $urandom_range(0, 99);
            if (k < 60) send_request(FUNC_PUT, CH_CR, ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            if (k < 85) send_request(FUNC_PUT, CH_LF, ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            random_items += n + (k < 60) + (k < 85);
         end else if (r < 62) begin
            // Reads: the cursor line, the line above, anywhere, or the ends.
            n = $urandom_range(1, 4);
            repeat (n) begin
               row_base = {cursor_model[11:7], 7'd0};
               k = $urandom_range(0, 99);
               if (k < 40) row_base = row_base + ADDR_W'($urandom_range(0, 127));
               else if (k < 60) row_base = row_base - ADDR_W'(LINE_CELLS)
                                           + ADDR_W'($urandom_range(0, 127));
               else if (k < 90) row_base = ADDR_W'($urandom_range(0, 4095));
               else row_base = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
               send_request(FUNC_READ, CHAR_W'($urandom_range(0, 255)), row_base, 1'b0, '0);
            end
            random_items += n;
         end else if (r < 67) begin
            // Blank lines, each one scrolling once the cursor is on the last line.
            n = $urandom_range(1, 3);
            repeat (n) send_request(FUNC_PUT, CH_LF, ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            random_items += n;
         end else if (r < 80) begin
            // Backspace and delete, sometimes after a return to column 0.
            k = $urandom_range(0, 9);
            if (k < 3) send_request(FUNC_PUT, CH_CR, ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            n = (k == 9) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            repeat (n) send_request(FUNC_PUT, ($urandom_range(0, 1) == 1) ? CH_BS : CH_DEL,
                                    ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            random_items += n + (k < 3);
         end else if (r < 90) begin
            // Return to column 0 and overwrite part of the line.
            n = $urandom_range(1, 20);
            send_request(FUNC_PUT, CH_CR, ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            repeat (n) send_request(FUNC_PUT, text_byte(), ADDR_W'($urandom_range(0, 4095)),
                                    1'b0, '0);
            random_items += n + 1;
         end else begin
            // Noise: any function, any byte, any address.
            n = $urandom_range(1, 5);
            repeat (n) send_request($urandom_range(0, 1) == 1 ? FUNC_READ : FUNC_PUT,
                                    CHAR_W'($urandom_range(0, 255)),
                                    ADDR_W'($urandom_range(0, 4095)), 1'b0, '0);
            random_items += n;
         end
      end
      req_valid <= 1'b0;

      while (awaited_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d puts and %0d reads, with %0d line feeds and %0d scrolls.",
               put_count, read_count, lf_count, scroll_count);
      $display("Responses were checked field by field; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("text_console_writer test passed");
      end else begin
         $display("text_console_writer test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, including the clear sweep.
   initial begin : watchdog
      #400_000_000;
      $display("text_console_writer test failed");
      $finish;
   end

endmodule

[filelist.f]
src/tcw_pkg.sv
src/text_console_writer.sv
sim/text_console_writer_tb.sv
